>>> design/kne_pkg.sv
// Package with the shared types, key codes and helper functions of the keyed number entry unit.
`timescale 1ns / 1ps
`default_nettype none
package kne_pkg;

	localparam int BASE_W = 5;
	localparam int DIGITS_W = 5;
	localparam int DIGIT_W = 4;
	localparam int OUT_VALUE_W = 64;

	localparam logic [7:0] KEY_BS = 8'd8;
	localparam logic [7:0] KEY_LF = 8'd10;
	localparam logic [7:0] KEY_CR = 8'd13;
	localparam logic [7:0] KEY_ESC = 8'd27;
	localparam logic [7:0] KEY_SPACE = 8'd32;
	localparam logic [7:0] CH_0 = 8'd48;
	localparam logic [7:0] CH_9 = 8'd57;
	localparam logic [7:0] CH_LA = 8'd97;
	localparam logic [7:0] CH_LF = 8'd102;
	localparam logic [7:0] CH_LX = 8'd120;
	localparam logic [7:0] HEX_OFS = 8'd87;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_ECHO = 2'd1;
	localparam logic [1:0] ACT_ERASE = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_ABORT = 2'd2;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MAXD = 1'b1;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
	localparam logic [DIGITS_W-1:0] LIMIT_MIN = 5'd1;
	localparam logic [DIGITS_W-1:0] LIMIT_MAX = 5'd20;
	localparam logic [BASE_W-1:0] BASE_RESET = 5'd16;
	localparam logic [DIGITS_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_BUSY,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		KC_NONE,
		KC_DIGIT,
		KC_ERASE,
		KC_END,
		KC_ABORT
	} key_class_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} arith_op_t;

	typedef struct packed {
		logic start;
		arith_op_t op;
		logic [BASE_W-1:0] base;
		logic [DIGIT_W-1:0] digit;
	} arith_cmd_t;

	function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN) r = BASE_MIN;
		if (b > BASE_MAX) r = BASE_MAX;
		return r;
	endfunction

	function automatic logic [DIGITS_W-1:0] eff_limit(input logic [DIGITS_W-1:0] m);
		logic [DIGITS_W-1:0] r;
		r = m;
		if (m < LIMIT_MIN) r = LIMIT_MIN;
		if (m > LIMIT_MAX) r = LIMIT_MAX;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/keyed_number_entry_unit.sv
// Top level of the keyed number entry unit: key decode, entry state, sequencer and result register.
// Usage: one keystroke code per item arrives on key with in_valid/in_ready; one result
// item per key leaves on echo_action, echo_char, done_res, status and value with
// out_valid/out_ready. The configuration port (cfg_we, cfg_index, cfg_data) sets the
// base (index 0) and the digit limit (index 1); write it only while the unit is idle.
// A digit key runs a shift-add multiply by the base in the shared unit. Backspace and
// 'x', when they erase a digit, run the restoring divide by the base that produces one
// quotient bit a cycle. Other keys skip the shared unit. One item is in the unit at a
// time; in_ready is high only when the sequencer is idle, so a new key is not taken
// until the last one has its result loaded into the result register.
// The result register holds a finished result while the receiver stalls; the next
// item can already be accepted, but its result waits until the register is free.
// Reset clears the entry (value and digit count), sets the base to 16 and the
// digit limit to 16, and leaves no result pending.
`timescale 1ns / 1ps
`default_nettype none
module keyed_number_entry_unit #(
	parameter int VALUE_WIDTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] key,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] echo_action,
	output logic [7:0] echo_char,
	output logic done_res,
	output logic [1:0] status,
	output logic [kne_pkg::OUT_VALUE_W-1:0] value,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [kne_pkg::BASE_W-1:0] cfg_data
);

	kne_pkg::state_t state_q;
	kne_pkg::state_t state_d;
	kne_pkg::key_class_t kc_q;
	kne_pkg::key_class_t kc;
	kne_pkg::arith_cmd_t cmd;

	logic [kne_pkg::BASE_W-1:0] base_q;
	logic [kne_pkg::DIGITS_W-1:0] maxd_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [kne_pkg::DIGITS_W-1:0] cnt_q;
	logic [7:0] key_q;

	logic out_valid_q;
	logic [1:0] act_q;
	logic [7:0] echo_q;
	logic done_q;
	logic [1:0] stat_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic [kne_pkg::BASE_W-1:0] base_eff;
	logic [kne_pkg::DIGITS_W-1:0] limit_eff;
	logic [kne_pkg::DIGIT_W-1:0] digit;
	logic [7:0] digit_raw;
	logic [VALUE_WIDTH-1:0] ar_result;
	logic ar_done;
	logic fin_load;
	logic fin_done;
	logic [1:0] fin_stat;
	logic [1:0] fin_act;
	logic [7:0] fin_echo;
	logic [VALUE_WIDTH-1:0] fin_val;

	assign base_eff = kne_pkg::eff_base(base_q);
	assign limit_eff = kne_pkg::eff_limit(maxd_q);

	always_comb begin
		kc = kne_pkg::KC_NONE;
		digit_raw = 8'd0;
		if (key_q >= kne_pkg::CH_0 && key_q <= kne_pkg::CH_9) begin
			kc = kne_pkg::KC_DIGIT;
			digit_raw = key_q - kne_pkg::CH_0;
		end else if (key_q >= kne_pkg::CH_LA && key_q <= kne_pkg::CH_LF
				&& base_eff == kne_pkg::BASE_MAX) begin
			kc = kne_pkg::KC_DIGIT;
			digit_raw = key_q - kne_pkg::HEX_OFS;
		end else if (key_q == kne_pkg::KEY_BS) begin
			if (cnt_q != '0) kc = kne_pkg::KC_ERASE;
		end else if (key_q == kne_pkg::CH_LX) begin
			if (base_eff == kne_pkg::BASE_MAX && cnt_q != '0 && acc_q[3:0] == 4'd0) begin
				kc = kne_pkg::KC_ERASE;
			end
		end else if (key_q == kne_pkg::KEY_SPACE || key_q == kne_pkg::KEY_CR
				|| key_q == kne_pkg::KEY_LF) begin
			kc = kne_pkg::KC_END;
		end else if (key_q == kne_pkg::KEY_ESC) begin
			kc = kne_pkg::KC_ABORT;
		end
		digit = digit_raw[kne_pkg::DIGIT_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		cmd.start = 1'b0;
		cmd.op = kne_pkg::OP_MUL;
		cmd.base = base_eff;
		cmd.digit = digit;
		fin_load = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			kne_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = kne_pkg::ST_EXEC;
			end
			kne_pkg::ST_EXEC: begin
				if (kc == kne_pkg::KC_DIGIT || kc == kne_pkg::KC_ERASE) begin
					cmd.start = 1'b1;
					cmd.op = (kc == kne_pkg::KC_DIGIT) ? kne_pkg::OP_MUL : kne_pkg::OP_DIV;
					state_d = kne_pkg::ST_BUSY;
				end else begin
					state_d = kne_pkg::ST_FIN;
				end
			end
			kne_pkg::ST_BUSY: begin
				if (ar_done) state_d = kne_pkg::ST_FIN;
			end
			kne_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					fin_load = 1'b1;
					state_d = kne_pkg::ST_IDLE;
				end
			end
			default: state_d = kne_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		fin_done = 1'b0;
		fin_stat = kne_pkg::STAT_OK;
		if (kc_q == kne_pkg::KC_ABORT) begin
			fin_done = 1'b1;
			fin_stat = kne_pkg::STAT_ABORT;
		end else if (kc_q == kne_pkg::KC_END) begin
			fin_done = 1'b1;
			fin_stat = (cnt_q == '0) ? kne_pkg::STAT_EMPTY : kne_pkg::STAT_OK;
		end else if (cnt_q >= limit_eff) begin
			fin_done = 1'b1;
		end
		fin_val = (fin_done && fin_stat == kne_pkg::STAT_OK) ? acc_q : '0;
		fin_act = kne_pkg::ACT_NONE;
		fin_echo = 8'd0;
		if (kc_q == kne_pkg::KC_DIGIT) begin
			fin_act = kne_pkg::ACT_ECHO;
			fin_echo = key_q;
		end else if (kc_q == kne_pkg::KC_ERASE) begin
			fin_act = kne_pkg::ACT_ERASE;
		end
	end

	kne_arith #(
		.W(VALUE_WIDTH)
	) u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.operand(acc_q),
		.result(ar_result),
		.done(ar_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kne_pkg::ST_IDLE;
			base_q <= kne_pkg::BASE_RESET;
			maxd_q <= kne_pkg::LIMIT_RESET;
			acc_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == kne_pkg::REG_BASE) begin
					base_q <= cfg_data;
				end else begin
					maxd_q <= cfg_data;
				end
			end
			if (state_q == kne_pkg::ST_BUSY && ar_done) begin
				acc_q <= ar_result;
				if (kc_q == kne_pkg::KC_DIGIT) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (fin_load && fin_done) begin
				acc_q <= '0;
				cnt_q <= '0;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q <= key;
		end
		if (state_q == kne_pkg::ST_EXEC) begin
			kc_q <= kc;
		end
		if (fin_load) begin
			act_q <= fin_act;
			echo_q <= fin_echo;
			done_q <= fin_done;
			stat_q <= fin_done ? fin_stat : kne_pkg::STAT_OK;
			val_q <= fin_val;
		end
	end

	assign out_valid = out_valid_q;
	assign echo_action = act_q;
	assign echo_char = echo_q;
	assign done_res = done_q;
	assign status = stat_q;
	assign value = kne_pkg::OUT_VALUE_W'(val_q);

endmodule
`default_nettype wire

>>> design/kne_arith.sv
// Shared iterative unit: shift-add multiply-accumulate by the base and restoring divide by the base.
`timescale 1ns / 1ps
`default_nettype none
module kne_arith #(
	parameter int W = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire kne_pkg::arith_cmd_t cmd,
	input wire logic [W-1:0] operand,
	output logic [W-1:0] result,
	output logic done
);

	localparam int CNT_W = $clog2(W + 1);
	localparam int REM_W = kne_pkg::BASE_W - 1;

	logic busy_q;
	logic done_q;
	kne_pkg::arith_op_t op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] opd_q;
	logic [kne_pkg::BASE_W-1:0] bb_q;
	logic [kne_pkg::BASE_W-1:0] div_q;
	logic [REM_W-1:0] rem_q;

	logic [W-1:0] sum;
	logic [kne_pkg::BASE_W-1:0] trial;
	logic [kne_pkg::BASE_W-1:0] trial_sub;
	logic q_bit;

	assign sum = acc_q + opd_q;
	assign trial = {rem_q, opd_q[W-1]};
	assign q_bit = (trial >= div_q);
	assign trial_sub = trial - div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				if (cmd.op == kne_pkg::OP_MUL) begin
					cnt_q <= CNT_W'(kne_pkg::BASE_W);
				end else begin
					cnt_q <= CNT_W'(W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= cmd.op;
			acc_q <= W'(cmd.digit);
			opd_q <= operand;
			bb_q <= cmd.base;
			div_q <= cmd.base;
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == kne_pkg::OP_MUL) begin
				if (bb_q[0]) begin
					acc_q <= sum;
				end
				opd_q <= {opd_q[W-2:0], 1'b0};
				bb_q <= {1'b0, bb_q[kne_pkg::BASE_W-1:1]};
			end else begin
				if (q_bit) begin
					rem_q <= trial_sub[REM_W-1:0];
				end else begin
					rem_q <= trial[REM_W-1:0];
				end
				opd_q <= {opd_q[W-2:0], q_bit};
			end
		end
	end

	assign result = (op_q == kne_pkg::OP_MUL) ? acc_q : opd_q;
	assign done = done_q;

endmodule
`default_nettype wire
